// ----- src/segment_intersection_macros.svh -----
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared concurrent assertion wrappers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment_intersection assertion failed");
// next-cycle implication
`define SI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment_intersection assertion failed");
`else
`define SI_ASSERT_IMP(lbl, ante, cons)
`define SI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- src/si_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, relation codes and the beat carried through the divider stages.
// ----------------------------------------------------------------------------
package si_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CW          = COORD_WIDTH;
  // deltas carry one extra bit
  localparam int DLW         = CW + 1;
  // products of two deltas
  localparam int PW          = 2 * DLW;
  // denominator and numerators
  localparam int DW          = PW + 1;
  // quotient magnitude bits (bounded by |delta|)
  localparam int QW          = CW + 1;
  // scaled numerator magnitude
  localparam int NUMW        = DW + DLW;

  localparam logic [1:0] REL_NONE       = 2'd0;
  localparam logic [1:0] REL_HIT        = 2'd1;
  localparam logic [1:0] REL_PARALLEL   = 2'd2;
  localparam logic [1:0] REL_COINCIDENT = 2'd3;

  typedef struct packed {
    logic                 hit;
    logic [1:0]           rel;
    logic signed [CW-1:0] x1s;
    logic signed [CW-1:0] y1s;
    logic [NUMW-1:0]      remx;
    logic [NUMW-1:0]      remy;
    logic [NUMW-1:0]      dsh;
    logic                 negx;
    logic                 negy;
    logic [QW-1:0]        qx;
    logic [QW-1:0]        qy;
  } si_beat_t;

endpackage

// ----- src/si_front.sv -----
// ----------------------------------------------------------------------------
// Segment intersection front end
// Five stages: deltas, cross products, sums, classification, numerator scale.
// ----------------------------------------------------------------------------
module si_front import si_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_in,
  input  logic signed [CW-1:0] x1s_in,
  input  logic signed [CW-1:0] y1s_in,
  input  logic signed [CW-1:0] x1e_in,
  input  logic signed [CW-1:0] y1e_in,
  input  logic signed [CW-1:0] x2s_in,
  input  logic signed [CW-1:0] y2s_in,
  input  logic signed [CW-1:0] x2e_in,
  input  logic signed [CW-1:0] y2e_in,
  output logic                 v_out,
  output si_beat_t             beat_out
);

  logic [4:0] v_r, v_nxt;

  // stage 1
  logic signed [CW-1:0]  s1_x1s_r, s1_y1s_r;
  logic signed [DLW-1:0] s1_dx1_r, s1_dy1_r, s1_dx2_r, s1_dy2_r, s1_ox_r, s1_oy_r;
  // stage 2
  logic signed [CW-1:0]  s2_x1s_r, s2_y1s_r;
  logic signed [DLW-1:0] s2_dx1_r, s2_dy1_r;
  logic signed [PW-1:0]  s2_pd1_r, s2_pd2_r, s2_pa1_r, s2_pa2_r, s2_pb1_r, s2_pb2_r;
  // stage 3
  logic signed [CW-1:0]  s3_x1s_r, s3_y1s_r;
  logic signed [DLW-1:0] s3_dx1_r, s3_dy1_r;
  logic signed [DW-1:0]  s3_den_r, s3_na_r, s3_nb_r;
  // stage 4
  logic signed [CW-1:0]  s4_x1s_r, s4_y1s_r;
  logic                  s4_hit_r;
  logic [1:0]            s4_rel_r;
  logic [DW-1:0]         s4_mna_r, s4_mden_r;
  logic [DLW-1:0]        s4_mdx_r, s4_mdy_r;
  logic                  s4_nx_r, s4_ny_r;
  // stage 5
  si_beat_t              s5_r;

  // stage 4 classification
  logic                  den_zero, den_neg;
  logic signed [DW-1:0]  d_pos, a_pos, b_pos, da, db;
  logic                  in_a, in_b;
  logic [1:0]            rel_nxt;
  logic                  hit_nxt;

  assign v_nxt = {v_r[3:0], v_in};

  always_comb begin
    den_zero = (s3_den_r == '0);
    den_neg  = s3_den_r[DW-1];
    d_pos    = den_neg ? -s3_den_r : s3_den_r;
    a_pos    = den_neg ? -s3_na_r  : s3_na_r;
    b_pos    = den_neg ? -s3_nb_r  : s3_nb_r;
    da       = d_pos - a_pos;
    db       = d_pos - b_pos;
    in_a     = !a_pos[DW-1] && !da[DW-1];
    in_b     = !b_pos[DW-1] && !db[DW-1];
    hit_nxt  = 1'b0;
    if (den_zero) begin
      rel_nxt = (s3_na_r == '0 && s3_nb_r == '0) ? REL_COINCIDENT : REL_PARALLEL;
    end else if (in_a && in_b) begin
      rel_nxt = REL_HIT;
      hit_nxt = 1'b1;
    end else begin
      rel_nxt = REL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1s_r <= x1s_in;
      s1_y1s_r <= y1s_in;
      s1_dx1_r <= DLW'(x1e_in) - DLW'(x1s_in);
      s1_dy1_r <= DLW'(y1e_in) - DLW'(y1s_in);
      s1_dx2_r <= DLW'(x2e_in) - DLW'(x2s_in);
      s1_dy2_r <= DLW'(y2e_in) - DLW'(y2s_in);
      s1_ox_r  <= DLW'(x1s_in) - DLW'(x2s_in);
      s1_oy_r  <= DLW'(y1s_in) - DLW'(y2s_in);

      s2_x1s_r <= s1_x1s_r;
      s2_y1s_r <= s1_y1s_r;
      s2_dx1_r <= s1_dx1_r;
      s2_dy1_r <= s1_dy1_r;
      s2_pd1_r <= s1_dy2_r * s1_dx1_r;
      s2_pd2_r <= s1_dx2_r * s1_dy1_r;
      s2_pa1_r <= s1_dx2_r * s1_oy_r;
      s2_pa2_r <= s1_dy2_r * s1_ox_r;
      s2_pb1_r <= s1_dx1_r * s1_oy_r;
      s2_pb2_r <= s1_dy1_r * s1_ox_r;

      s3_x1s_r <= s2_x1s_r;
      s3_y1s_r <= s2_y1s_r;
      s3_dx1_r <= s2_dx1_r;
      s3_dy1_r <= s2_dy1_r;
      s3_den_r <= DW'(s2_pd1_r) - DW'(s2_pd2_r);
      s3_na_r  <= DW'(s2_pa1_r) - DW'(s2_pa2_r);
      s3_nb_r  <= DW'(s2_pb1_r) - DW'(s2_pb2_r);

      s4_x1s_r  <= s3_x1s_r;
      s4_y1s_r  <= s3_y1s_r;
      s4_hit_r  <= hit_nxt;
      s4_rel_r  <= rel_nxt;
      s4_mna_r  <= s3_na_r[DW-1] ? DW'(-s3_na_r) : DW'(s3_na_r);
      s4_mden_r <= DW'(d_pos);
      s4_mdx_r  <= s3_dx1_r[DLW-1] ? DLW'(-s3_dx1_r) : DLW'(s3_dx1_r);
      s4_mdy_r  <= s3_dy1_r[DLW-1] ? DLW'(-s3_dy1_r) : DLW'(s3_dy1_r);
      // quotient sign: numerator, delta and denominator signs
      s4_nx_r   <= s3_na_r[DW-1] ^ s3_dx1_r[DLW-1] ^ den_neg;
      s4_ny_r   <= s3_na_r[DW-1] ^ s3_dy1_r[DLW-1] ^ den_neg;

      s5_r.hit  <= s4_hit_r;
      s5_r.rel  <= s4_rel_r;
      s5_r.x1s  <= s4_x1s_r;
      s5_r.y1s  <= s4_y1s_r;
      s5_r.remx <= NUMW'(s4_mna_r) * NUMW'(s4_mdx_r);
      s5_r.remy <= NUMW'(s4_mna_r) * NUMW'(s4_mdy_r);
      s5_r.dsh  <= NUMW'(s4_mden_r) << (QW - 1);
      s5_r.negx <= s4_nx_r;
      s5_r.negy <= s4_ny_r;
      s5_r.qx   <= '0;
      s5_r.qy   <= '0;
    end
  end

  assign v_out    = v_r[4];
  assign beat_out = s5_r;

endmodule

// ----- src/si_div_step.sv -----
// ----------------------------------------------------------------------------
// Segment intersection divider step
// One restoring quotient bit for both coordinates per stage.
// ----------------------------------------------------------------------------
module si_div_step import si_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     v_in,
  input  si_beat_t beat_in,
  output logic     v_out,
  output si_beat_t beat_out
);

  logic     v_r;
  si_beat_t beat_r, beat_nxt;
  logic     gex, gey;

  always_comb begin
    gex      = (beat_in.remx >= beat_in.dsh);
    gey      = (beat_in.remy >= beat_in.dsh);
    beat_nxt = beat_in;
    if (gex) begin
      beat_nxt.remx = beat_in.remx - beat_in.dsh;
    end
    if (gey) begin
      beat_nxt.remy = beat_in.remy - beat_in.dsh;
    end
    beat_nxt.qx  = {beat_in.qx[QW-2:0], gex};
    beat_nxt.qy  = {beat_in.qy[QW-2:0], gey};
    beat_nxt.dsh = beat_in.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign v_out    = v_r;
  assign beat_out = beat_r;

endmodule

// ----- src/segment_intersection.sv -----
// ----------------------------------------------------------------------------
// Segment intersection
// Parametric two-segment intersection test with truncated hit point.
// ----------------------------------------------------------------------------
// Accepts one segment pair per cycle while in_stall is low and returns one
// result beat per pair, in order, through 5 front stages for deltas, cross
// products, sums, classification and numerator scaling, 17 divider stages
// that each settle one quotient bit, and the output register. The whole
// pipeline holds while a result waits and out_stall is high; in_stall
// follows. Point outputs are zero unless hit is set.
module segment_intersection import si_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_first_start_x,
  input  logic signed [CW-1:0] in_first_start_y,
  input  logic signed [CW-1:0] in_first_end_x,
  input  logic signed [CW-1:0] in_first_end_y,
  input  logic signed [CW-1:0] in_second_start_x,
  input  logic signed [CW-1:0] in_second_start_y,
  input  logic signed [CW-1:0] in_second_end_x,
  input  logic signed [CW-1:0] in_second_end_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [1:0]           out_relation,
  output logic signed [CW-1:0] out_point_x,
  output logic signed [CW-1:0] out_point_y
);

`include "segment_intersection_macros.svh"

  logic       en;
  logic       fv;
  si_beat_t   fbeat;
  logic       dv   [QW+1];
  si_beat_t   dbeat[QW+1];

  logic                 out_valid_r;
  logic                 hit_r;
  logic [1:0]           rel_r;
  logic signed [CW-1:0] px_r, py_r;
  logic [CW+1:0]        qxs, qys, px_sum, py_sum;
  si_beat_t             fin;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  si_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (in_valid),
    .x1s_in  (in_first_start_x),
    .y1s_in  (in_first_start_y),
    .x1e_in  (in_first_end_x),
    .y1e_in  (in_first_end_y),
    .x2s_in  (in_second_start_x),
    .y2s_in  (in_second_start_y),
    .x2e_in  (in_second_end_x),
    .y2e_in  (in_second_end_y),
    .v_out   (fv),
    .beat_out(fbeat)
  );

  assign dv[0]    = fv;
  assign dbeat[0] = fbeat;

  for (genvar g = 0; g < QW; g++) begin : g_div
    si_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (dv[g]),
      .beat_in (dbeat[g]),
      .v_out   (dv[g+1]),
      .beat_out(dbeat[g+1])
    );
  end

  always_comb begin
    fin    = dbeat[QW];
    qxs    = fin.negx ? (CW+2)'(-{2'b00, fin.qx}) : (CW+2)'({2'b00, fin.qx});
    qys    = fin.negy ? (CW+2)'(-{2'b00, fin.qy}) : (CW+2)'({2'b00, fin.qy});
    px_sum = (CW+2)'(fin.x1s) + qxs;
    py_sum = (CW+2)'(fin.y1s) + qys;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= fin.hit;
      rel_r <= fin.rel;
      px_r  <= fin.hit ? px_sum[CW-1:0] : '0;
      py_r  <= fin.hit ? py_sum[CW-1:0] : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_relation = rel_r;
  assign out_point_x  = px_r;
  assign out_point_y  = py_r;

  `SI_ASSERT_IMP(a_hit_rel, out_valid, out_hit == (out_relation == REL_HIT))
  `SI_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_point_x == '0 && out_point_y == '0)
  `SI_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_point_x))
  `SI_ASSERT_IMP(a_stall_src, in_stall, out_valid && out_stall)

endmodule

// ----- test/segment_intersection_checker.sv -----
// ----------------------------------------------------------------------------
// Segment intersection checker
// Watches both channels, predicts each result beat and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module segment_intersection_checker import si_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CW-1:0] in_first_start_x,
  input  logic signed [CW-1:0] in_first_start_y,
  input  logic signed [CW-1:0] in_first_end_x,
  input  logic signed [CW-1:0] in_first_end_y,
  input  logic signed [CW-1:0] in_second_start_x,
  input  logic signed [CW-1:0] in_second_start_y,
  input  logic signed [CW-1:0] in_second_end_x,
  input  logic signed [CW-1:0] in_second_end_y,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_hit,
  input  logic [1:0]           out_relation,
  input  logic signed [CW-1:0] out_point_x,
  input  logic signed [CW-1:0] out_point_y,
  output int                   errors,
  output int                   pending,
  output int                   hits_seen,
  output int                   parallel_seen,
  output int                   coincident_seen
);

  typedef struct packed {
    logic                 hit;
    logic [1:0]           rel;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } crossing_t;

  crossing_t crossing_q[$];

  // exact arithmetic in 128 bits; quotient truncates toward zero
  function automatic crossing_t find_crossing(
      input logic signed [CW-1:0] x1s, y1s, x1e, y1e, x2s, y2s, x2e, y2e);
    logic signed [127:0] dx1, dy1, dx2, dy2, ox, oy, den, na, nb, d, a, b, qx, qy;
    crossing_t r;
    dx1 = x1e - x1s;  dy1 = y1e - y1s;
    dx2 = x2e - x2s;  dy2 = y2e - y2s;
    ox  = x1s - x2s;  oy  = y1s - y2s;
    den = dy2 * dx1 - dx2 * dy1;
    na  = dx2 * oy - dy2 * ox;
    nb  = dx1 * oy - dy1 * ox;
    r = '0;
    r.rel = REL_NONE;
    if (den == 0) begin
      r.rel = (na == 0 && nb == 0) ? REL_COINCIDENT : REL_PARALLEL;
    end else begin
      d = den; a = na; b = nb;
      if (d < 0) begin
        d = -d; a = -a; b = -b;
      end
      if (a >= 0 && a <= d && b >= 0 && b <= d) begin
        qx = (na * dx1) / den;
        qy = (na * dy1) / den;
        r.px  = x1s + qx[CW-1:0];
        r.py  = y1s + qy[CW-1:0];
        r.hit = 1'b1;
        r.rel = REL_HIT;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    crossing_t e;
    if (!rst_n) begin
      errors = 0; hits_seen = 0; parallel_seen = 0; coincident_seen = 0;
      crossing_q.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crossing_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: actual %b %0d %0d %0d", $time,
                   out_hit, out_relation, out_point_x, out_point_y);
        end else begin
          e = crossing_q.pop_front();
          if (out_hit !== e.hit || out_relation !== e.rel ||
              out_point_x !== e.px || out_point_y !== e.py) begin
            errors++;
            $display("%0t: mismatch: expected hit %b rel %0d pt %0d,%0d", $time,
                     e.hit, e.rel, e.px, e.py,
                     " actual hit %b rel %0d pt %0d,%0d",
                     out_hit, out_relation, out_point_x, out_point_y);
          end
          if (e.rel == REL_HIT) hits_seen++;
          if (e.rel == REL_PARALLEL) parallel_seen++;
          if (e.rel == REL_COINCIDENT) coincident_seen++;
        end
      end
      if (in_valid && !in_stall)
        crossing_q.push_back(find_crossing(in_first_start_x, in_first_start_y,
            in_first_end_x, in_first_end_y, in_second_start_x, in_second_start_y,
            in_second_end_x, in_second_end_y));
      pending = crossing_q.size();
    end
  end

endmodule

// ----- test/segment_intersection_test.sv -----
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Directed corner pairs then random crossing, parallel, collinear and noisy
// pairs, with random gaps on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module segment_intersection_test import si_pkg::*;;

  localparam int RANDOM_PAIRS = 1930;
  localparam int WATCHDOG     = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, out_hit;
  logic [1:0] out_relation;
  logic signed [CW-1:0] out_point_x, out_point_y;
  logic signed [CW-1:0] x1s = '0, y1s = '0, x1e = '0, y1e = '0;
  logic signed [CW-1:0] x2s = '0, y2s = '0, x2e = '0, y2e = '0;
  int errors, pending, hits_seen, parallel_seen, coincident_seen;
  int pairs_sent = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit rx_took = 1'b0;
  bit long_hold = 1'b0;

  always #6 clk = ~clk;

  segment_intersection i_dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_first_start_x(x1s), .in_first_start_y(y1s),
    .in_first_end_x(x1e), .in_first_end_y(y1e),
    .in_second_start_x(x2s), .in_second_start_y(y2s),
    .in_second_end_x(x2e), .in_second_end_y(y2e),
    .out_valid, .out_stall, .out_hit, .out_relation, .out_point_x, .out_point_y
  );

  segment_intersection_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_first_start_x(x1s), .in_first_start_y(y1s),
    .in_first_end_x(x1e), .in_first_end_y(y1e),
    .in_second_start_x(x2s), .in_second_start_y(y2s),
    .in_second_end_x(x2e), .in_second_end_y(y2e),
    .out_valid, .out_stall, .out_hit, .out_relation, .out_point_x, .out_point_y,
    .errors, .pending, .hits_seen, .parallel_seen, .coincident_seen
  );

  // present one pair, hold it until accepted, then drop valid for a random gap
  task automatic send_pair(input logic signed [CW-1:0] a, b, c, d, e, f, g, h);
    int gap;
    x1s <= a; y1s <= b; x1e <= c; y1e <= d;
    x2s <= e; y2s <= f; x2e <= g; y2e <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pairs_sent++;
    gap = $urandom_range(0, 7);
    if (pairs_sent % 300 > 240) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic signed [CW-1:0] pick_coord(input int span);
    if (span == 0) return CW'($urandom);
    return CW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_pair();
    logic signed [CW-1:0] p[8];
    int kind, span, k, m;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2000);
    foreach (p[i]) p[i] = pick_coord(span);
    case (kind)
      0, 1: begin
        // segment two shifted along segment one: parallel or collinear
        k = $signed($urandom_range(0, 6)) - 3;
        m = $urandom_range(0, 1);
        p[4] = CW'(p[0] + k * (p[2] - p[0]) + m);
        p[5] = CW'(p[1] + k * (p[3] - p[1]));
        p[6] = p[4] + (p[2] - p[0]);         p[7] = p[5] + (p[3] - p[1]);
      end
      2: begin
        p[2] = p[0]; p[3] = p[1];
      end
      3: begin
        p[4] = p[0]; p[5] = p[1];
      end
      default: begin
        // build segment two through a point near segment one
        p[4] = (p[0] + p[2]) / 2 - pick_coord(1000);
        p[5] = (p[1] + p[3]) / 2 - pick_coord(1000);
        p[6] = CW'(2 * ((p[0] + p[2]) / 2) - p[4]);
        p[7] = CW'(2 * ((p[1] + p[3]) / 2) - p[5]);
      end
    endcase
    send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
  endtask

  // receiver: a random wait before each beat, one long hold-off
  always @(posedge clk) begin
    rx_took <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (long_hold) begin
        out_stall <= 1'b1;
      end else begin
        if (rx_took) rx_wait = $urandom_range(0, 7);
        if (rx_wait > 0) begin
          out_stall <= 1'b1;
          rx_wait--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // long hold-off while the sender keeps going
  initial begin
    int hold;
    wait (pairs_sent == 400);
    @(negedge clk);
    long_hold <= 1'b1;
    for (hold = 0; hold < 120; hold++) @(negedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // proper crossing at the middle
    send_pair(-160, 0, 160, 0, 0, -160, 0, 160);
    // endpoint touch, T-junction
    send_pair(0, 0, 320, 0, 320, -50, 320, 50);
    send_pair(0, 0, 320, 320, 0, 0, 5, -77);
    // lines cross outside the extents
    send_pair(0, 0, 16, 0, 100, -10, 100, 10);
    send_pair(0, 0, 16, 16, -16, 100, 16, 200);
    // parallel, collinear overlapping, collinear disjoint
    send_pair(0, 0, 100, 100, 0, 10, 100, 110);
    send_pair(0, 0, 100, 100, 50, 50, 200, 200);
    send_pair(0, 0, 100, 100, 300, 300, 400, 400);
    // zero-length segments
    send_pair(7, 7, 7, 7, 0, 0, 50, 50);
    send_pair(7, 7, 7, 7, 7, 7, 7, 7);
    send_pair(0, 0, 30, 30, 9, 9, 9, 9);
    // full-scale extremes
    send_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
    send_pair(MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC);
    send_pair(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
    send_pair(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC);
    send_pair(MINC, MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC);
    send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
    send_pair(MINC, 0, MAXC, 1, MAXC, 0, MINC, 1);
    // crossings with a positive and then a negative denominator, each a hit
    send_pair(100, -100, -100, 100, 100, 100, -100, -100);
    send_pair(-3, 5, 11, -7, 2, 9, -1, -13);
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      random_pair();
      // sender drains the pipeline once
      if (n == 1000) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("Sent %0d segment pairs: %0d crossings, %0d parallel, %0d collinear.",
             pairs_sent, hits_seen, parallel_seen, coincident_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
